// File: src/hrl_pkg.sv
package hrl_pkg;

  // Angles: Q3.13 at the ports, Q16 inside the CORDIC
  localparam int PI_Q13       = 25736;
  localparam int TWO_PI_Q13   = 51472;
  localparam int PI_Q16       = 205887;
  localparam int NORM_MIN_SQ  = 655;     // (0.1 m)^2 in Q16.16
  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W   = 5;
  localparam int SCALE_SH     = 14;      // CORDIC input pre-scale
  localparam int CORDIC_W     = 34;      // x/y datapath, covers gain and sqrt(2) growth
  localparam int ANGLE_W      = 20;      // z accumulator, Q16
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [14:0] MAX_STEP_RST   = 15'd2574;
  localparam logic [15:0] INV_PERIOD_RST = 16'd2560;
  localparam logic [14:0] MAX_RATE_RST   = 15'd804;

  typedef enum logic [1:0] {
    REG_MAX_STEP   = 2'd0,
    REG_INV_PERIOD = 2'd1,
    REG_MAX_RATE   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [14:0] max_step;
    logic [15:0] inv_period;
    logic [14:0] max_rate;
  } cfg_t;

  // Classified request passed from front to back
  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic               is_long;
  } item_t;

  // atan(2^-i) in Q16 rad
  function automatic logic [15:0] atan_q16(logic [ATAN_IDX_W-1:0] idx);
    logic [15:0] v;
    unique case (idx)
      5'd0:    v = 16'd51472;
      5'd1:    v = 16'd30386;
      5'd2:    v = 16'd16055;
      5'd3:    v = 16'd8150;
      5'd4:    v = 16'd4091;
      5'd5:    v = 16'd2047;
      5'd6:    v = 16'd1024;
      5'd7:    v = 16'd512;
      5'd8:    v = 16'd256;
      5'd9:    v = 16'd128;
      5'd10:   v = 16'd64;
      5'd11:   v = 16'd32;
      5'd12:   v = 16'd16;
      5'd13:   v = 16'd8;
      5'd14:   v = 16'd4;
      5'd15:   v = 16'd2;
      5'd16:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// File: src/hrl_if.sv
// Direction input channel
interface hrl_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  modport source (output valid, dir_x, dir_y, input ready);
  modport sink   (input valid, dir_x, dir_y, output ready);
endinterface

// Heading result channel
interface hrl_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] heading;
  logic signed [15:0] heading_rate;
  modport source (output valid, heading, heading_rate, input ready);
  modport sink   (input valid, heading, heading_rate, output ready);
endinterface

// Register write channel
interface hrl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/hrl_front.sv
module hrl_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  hrl_in_if.sink         in_i,
  output logic           push_valid_o,
  output hrl_pkg::item_t push_data_o,
  input  logic           push_ready_i
);

  typedef enum logic [1:0] {F_IDLE, F_SQX, F_SQY, F_PUSH} fstate_e;

  fstate_e            state_q;
  logic signed [15:0] x_q, y_q;
  logic [31:0]        sq_q;
  logic               long_q;

  logic signed [31:0] xx, yy;
  logic [32:0]        norm_sq;

  // two squarers: x^2 is registered in F_SQX, then y^2 is added to it in F_SQY
  assign xx      = x_q * x_q;
  assign yy      = y_q * y_q;
  assign norm_sq = {1'b0, sq_q} + {1'b0, $unsigned(yy)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (in_i.valid) begin
            x_q     <= in_i.dir_x;
            y_q     <= in_i.dir_y;
            state_q <= F_SQX;
          end
        end
        F_SQX: begin
          sq_q    <= $unsigned(xx);
          state_q <= F_SQY;
        end
        F_SQY: begin
          long_q  <= norm_sq > 33'(hrl_pkg::NORM_MIN_SQ);
          state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign in_i.ready           = (state_q == F_IDLE);
  assign push_valid_o         = (state_q == F_PUSH);
  assign push_data_o.dir_x    = x_q;
  assign push_data_o.dir_y    = y_q;
  assign push_data_o.is_long  = long_q;

endmodule

// File: src/hrl_queue.sv
module hrl_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  hrl_pkg::item_t push_data_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output hrl_pkg::item_t pop_data_o,
  input  logic           pop_ready_i
);

  localparam int Depth = hrl_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  hrl_pkg::item_t  entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_cnt_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count missed a push");
`endif

endmodule

// File: src/hrl_back.sv
module hrl_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  input  hrl_pkg::item_t pop_data_i,
  output logic           pop_ready_o,
  input  hrl_pkg::cfg_t  cfg_i,
  hrl_out_if.source      out_o
);

  localparam int CW = hrl_pkg::CORDIC_W;
  localparam int AW = hrl_pkg::ANGLE_W;
  localparam int IW = hrl_pkg::ATAN_IDX_W;
  localparam int NIter = (CORDIC_STEPS < hrl_pkg::ATAN_ENTRIES) ?
                         CORDIC_STEPS : hrl_pkg::ATAN_ENTRIES;
  localparam logic [IW-1:0] LastIt = IW'(NIter - 1);

  localparam logic signed [AW-1:0] PiZ   = AW'(hrl_pkg::PI_Q16);
  localparam logic signed [AW-1:0] PiZ13 = AW'(hrl_pkg::PI_Q13);
  localparam logic signed [18:0]   Pi19  = 19'(hrl_pkg::PI_Q13);
  localparam logic signed [18:0]   TwoPi = 19'(hrl_pkg::TWO_PI_Q13);
  localparam logic signed [15:0]   Pi16  = 16'(hrl_pkg::PI_Q13);
  localparam logic signed [33:0]   SatHi = 34'sd32767;
  localparam logic signed [33:0]   SatLo = -34'sd32768;

  typedef enum logic [2:0] {
    B_IDLE, B_PRE, B_ITER, B_ROUND, B_DIFF, B_MUL, B_FIN, B_OUT
  } bstate_e;

  bstate_e              state_q;
  logic signed [15:0]   x_q, y_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [AW-1:0] cz_q;
  logic [IW-1:0]        it_q;
  logic signed [15:0]   target_q;
  logic signed [16:0]   d_q;
  logic signed [33:0]   prod_q;
  logic signed [15:0]   yaw_q, rate_q;
  logic signed [15:0]   prev_heading_q, prev_rate_q;
  logic                 out_valid_q;

  // wrap once by +-2*pi and clamp to +-pi
  function automatic logic signed [15:0] wrap_once(logic signed [18:0] h);
    logic signed [18:0] w;
    if (h < -Pi19) begin
      w = h + TwoPi;
    end else if (h > Pi19) begin
      w = h - TwoPi;
    end else begin
      w = h;
    end
    if (w < -Pi19) begin
      w = -Pi19;
    end else if (w > Pi19) begin
      w = Pi19;
    end
    return w[15:0];
  endfunction

  // pre-rotation for the left half plane, then scale
  logic signed [16:0]   x17, y17, xn, yn;
  logic signed [CW-1:0] xe, ye;
  logic signed [AW-1:0] z0;

  assign x17 = {x_q[15], x_q};
  assign y17 = {y_q[15], y_q};
  assign xn  = x_q[15] ? -x17 : x17;
  assign yn  = x_q[15] ? -y17 : y17;
  assign xe  = CW'(xn);
  assign ye  = CW'(yn);
  assign z0  = !x_q[15] ? '0 : (y_q[15] ? -PiZ : PiZ);

  // one vectoring micro-rotation
  logic signed [CW-1:0] xs, ys;
  logic signed [AW-1:0] atan_s;

  assign xs     = cx_q >>> it_q;
  assign ys     = cy_q >>> it_q;
  assign atan_s = $signed(AW'(hrl_pkg::atan_q16(it_q)));

  // round Q16 to Q13 and clamp to +-pi
  logic signed [AW-1:0] zr;
  logic signed [15:0]   zc;

  assign zr = (cz_q + AW'(4)) >>> 3;
  always_comb begin
    if (zr < -PiZ13) begin
      zc = -Pi16;
    end else if (zr > PiZ13) begin
      zc = Pi16;
    end else begin
      zc = zr[15:0];
    end
  end

  // step limiting, rate and filtering
  logic signed [18:0] last19, tgt19, d19, m19, yaw19, diff19, adiff19, hsum19;
  logic signed [15:0] r16, rate_sel, rate_cmp, yaw_sel;
  logic signed [33:0] raw, sat, r34;
  logic signed [16:0] rsum17;

  assign last19 = {{3{prev_heading_q[15]}}, prev_heading_q};
  assign tgt19  = {{3{target_q[15]}}, target_q};
  assign d19    = {{2{d_q[16]}}, d_q};
  assign m19    = {4'b0, cfg_i.max_step};
  assign r16    = {1'b0, cfg_i.max_rate};
  assign r34    = {19'b0, cfg_i.max_rate};
  assign raw    = (prod_q + 34'sd4096) >>> 13;

  always_comb begin
    if (raw > SatHi) begin
      sat = SatHi;
    end else if (raw < SatLo) begin
      sat = SatLo;
    end else begin
      sat = raw;
    end
    if (sat > r34) begin
      rate_cmp = r16;
    end else if (sat < -r34) begin
      rate_cmp = -r16;
    end else begin
      rate_cmp = sat[15:0];
    end
  end

  always_comb begin
    priority if (d19 > Pi19) begin
      yaw_sel  = (d19 - TwoPi < -m19) ? wrap_once(last19 - m19) : target_q;
      rate_sel = -r16;
    end else if (d19 < -Pi19) begin
      yaw_sel  = (d19 + TwoPi > m19) ? wrap_once(last19 + m19) : target_q;
      rate_sel = r16;
    end else if (d19 < -m19) begin
      yaw_sel  = wrap_once(last19 - m19);
      rate_sel = -r16;
    end else if (d19 > m19) begin
      yaw_sel  = wrap_once(last19 + m19);
      rate_sel = r16;
    end else begin
      yaw_sel  = target_q;
      rate_sel = rate_cmp;
    end
  end

  assign yaw19   = {{3{yaw_sel[15]}}, yaw_sel};
  assign diff19  = yaw19 - last19;
  assign adiff19 = diff19[18] ? -diff19 : diff19;
  assign hsum19  = (last19 + yaw19) >>> 1;
  assign rsum17  = ({prev_rate_q[15], prev_rate_q} + {rate_sel[15], rate_sel}) >>> 1;

  // sequencer; result lives in prev_* which also drive the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= B_IDLE;
      out_valid_q    <= 1'b0;
      prev_heading_q <= '0;
      prev_rate_q    <= '0;
    end else begin
      // B_OUT owns the valid flag while it hands over a new result
      if (out_valid_q && out_o.ready && (state_q != B_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (pop_valid_i) begin
            x_q <= pop_data_i.dir_x;
            y_q <= pop_data_i.dir_y;
            if (pop_data_i.is_long) begin
              state_q <= B_PRE;
            end else begin
              target_q <= prev_heading_q;
              state_q  <= B_DIFF;
            end
          end
        end
        B_PRE: begin
          cx_q    <= xe <<< hrl_pkg::SCALE_SH;
          cy_q    <= ye <<< hrl_pkg::SCALE_SH;
          cz_q    <= z0;
          it_q    <= '0;
          state_q <= B_ITER;
        end
        B_ITER: begin
          if (cy_q > 0) begin
            cx_q <= cx_q + ys;
            cy_q <= cy_q - xs;
            cz_q <= cz_q + atan_s;
          end else begin
            cx_q <= cx_q - ys;
            cy_q <= cy_q + xs;
            cz_q <= cz_q - atan_s;
          end
          if (it_q == LastIt) begin
            state_q <= B_ROUND;
          end else begin
            it_q <= it_q + 1'b1;
          end
        end
        B_ROUND: begin
          target_q <= zc;
          state_q  <= B_DIFF;
        end
        B_DIFF: begin
          d_q     <= {target_q[15], target_q} - {prev_heading_q[15], prev_heading_q};
          state_q <= B_MUL;
        end
        B_MUL: begin
          prod_q  <= d_q * $signed({1'b0, cfg_i.inv_period});
          state_q <= B_FIN;
        end
        B_FIN: begin
          yaw_q   <= (adiff19 <= m19) ? hsum19[15:0] : yaw_sel;
          rate_q  <= rsum17[15:0];
          state_q <= B_OUT;
        end
        B_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            prev_heading_q <= yaw_q;
            prev_rate_q    <= rate_q;
            out_valid_q    <= 1'b1;
            state_q        <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign pop_ready_o        = (state_q == B_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.heading      = prev_heading_q;
  assign out_o.heading_rate = prev_rate_q;

`ifndef SYNTHESIS
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (prev_heading_q >= -Pi16 && prev_heading_q <= Pi16))
    else $error("heading outside +-pi");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_ITER) |-> it_q <= LastIt)
    else $error("CORDIC iteration count overrun");
`endif

endmodule

// File: src/heading_rate_limiter.sv
// Heading tracker: each request (dir_x, dir_y) gives exactly one result
// (heading, heading_rate), in order. Vectors longer than 0.1 m set a new
// target heading through a CORDIC atan2 of min(CORDIC_STEPS, 24) iterations;
// shorter ones hold the last heading. The change per request is limited to
// max_step, the rate to +-max_rate; the rate is always averaged with the
// previous result, the heading only when its change is within max_step.
// The front end takes one request at a time, squares it and pushes it
// into a 2-entry queue, holding while the queue is full. The back end takes
// one item at a time: a long vector passes B_PRE, the B_ITER loop, B_ROUND,
// B_DIFF, B_MUL, B_FIN and B_OUT, a short one goes straight to B_DIFF, and
// the iterative CORDIC loop sets the sustained rate. Register writes (index
// 0 max_step, 1 inv_period, 2 max_rate) are always ready and must be issued
// only while no request is in flight; other indexes are ignored.
module heading_rate_limiter #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hrl_in_if.sink    in_i,
  hrl_out_if.source out_o,
  hrl_cfg_if.sink   cfg_i
);

  hrl_pkg::cfg_t  cfg_q;
  logic           push_valid, push_ready, pop_valid, pop_ready;
  hrl_pkg::item_t push_data, pop_data;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_step   <= hrl_pkg::MAX_STEP_RST;
      cfg_q.inv_period <= hrl_pkg::INV_PERIOD_RST;
      cfg_q.max_rate   <= hrl_pkg::MAX_RATE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        hrl_pkg::REG_MAX_STEP:   cfg_q.max_step   <= cfg_i.data[14:0];
        hrl_pkg::REG_INV_PERIOD: cfg_q.inv_period <= cfg_i.data;
        hrl_pkg::REG_MAX_RATE:   cfg_q.max_rate   <= cfg_i.data[14:0];
        default: ;
      endcase
    end
  end

  hrl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  hrl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  hrl_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .cfg_i       (cfg_q),
    .out_o       (out_o)
  );

endmodule
